/* sv/hsv_color_adjust_macros.svh */
// Assertion macros shared by the HSV color adjust block.
// Needs nothing else; included by the files that hold assertions.
`ifndef HSV_COLOR_ADJUST_MACROS_SVH
`define HSV_COLOR_ADJUST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hsvc_pkg.sv */
// Shared types, constants and tables of the HSV color adjust block.
// Depends on nothing; used by every module of the block but hsvc_div.
package hsvc_pkg;

  localparam int CH_W   = 8;
  localparam int FRAC   = 4;
  localparam int MAXC   = (1 << CH_W) - 1;
  localparam int DEG60  = 60 << FRAC;
  localparam int TURN   = 6 * DEG60;
  localparam int FULL   = 100 << FRAC;

  localparam int V_W    = 11;   // value and saturation, 0..FULL
  localparam int H_W    = 13;   // hue, 0..TURN
  localparam int K_W    = 10;   // shift from sector center, 0..DEG60
  localparam int ROT_W  = 14;
  localparam int OFS_W  = 12;
  localparam int CFG_W  = 14;

  // Forward dividers: saturation and hue offset.
  localparam int SNUM_W = 20;
  localparam int SDEN_W = CH_W + 1;
  localparam int SQ_W   = 11;

  // Back conversion, rounded division by FULL^2 * DEG60 = 600000 << 3F.
  // The low 3F bits are dropped first, then the division by 600000 is a
  // multiplication by ceil(2^48 / 600000), exact for a 28-bit dividend.
  localparam int CNUM_W = 40;
  localparam int CDEN_W = 32;
  localparam logic [CDEN_W-1:0] CDEN = 32'd2457600000;
  localparam logic [CNUM_W-1:0] CHALF = 40'd1228800000;
  localparam int CSHIFT  = 3 * FRAC;
  localparam int CREC_W  = 29;
  localparam int CREC_SH = 48;
  localparam logic [CREC_W-1:0] CREC = 29'd469124962;
  localparam int CH_STAGES = 4;

  localparam logic [1:0] CFG_HUE_ROT = 2'd0;
  localparam logic [1:0] CFG_SAT_OFF = 2'd1;
  localparam logic [1:0] CFG_VAL_OFF = 2'd2;

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  typedef struct packed {
    sector_t sector;
    logic    plus;
    logic    gray;
    logic    black;
  } hue_info_t;

  typedef struct packed {
    logic [V_W-1:0] v;
    hue_info_t      info;
  } side_t;

  typedef logic [V_W-1:0] vlut_t [1 << CH_W];

  // Rounded value of each channel maximum, full scale FULL.
  function automatic vlut_t build_vlut();
    vlut_t t;
    for (int i = 0; i < (1 << CH_W); i++) begin
      t[i] = V_W'((2 * FULL * i + MAXC) / (2 * MAXC));
    end
    return t;
  endfunction

  localparam vlut_t V_LUT = build_vlut();

endpackage

/* sv/hsv_color_adjust.sv */
// HSV color adjust: one RGB pixel word in, one adjusted RGB pixel word out.
// Depends on hsvc_pkg, hsvc_fwd, hsvc_div, hsvc_adj, hsvc_chan and the macros header.
//
// The block takes one pixel word per clock while in_ready is high and returns
// one word per pixel, in order. The pipe has 19 stages: one sort stage, eleven
// stages of the two restoring dividers for saturation and hue offset, three
// adjust stages and four back conversion stages (product, full product,
// reciprocal multiplication, result). Every stage has a valid bit; a stage
// loads whenever it or some stage after it is empty, so bubbles close up and
// new words keep entering while a finished word waits at the output. Hue
// rotation, saturation offset and value offset are written on the cfg port
// while no word is in flight; they reset to zero.
`include "hsv_color_adjust_macros.svh"

module hsv_color_adjust (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsvc_pkg::CH_W-1:0]   in_red,
  input  logic [hsvc_pkg::CH_W-1:0]   in_green,
  input  logic [hsvc_pkg::CH_W-1:0]   in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsvc_pkg::CH_W-1:0]   out_red,
  output logic [hsvc_pkg::CH_W-1:0]   out_green,
  output logic [hsvc_pkg::CH_W-1:0]   out_blue,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [hsvc_pkg::CFG_W-1:0]  cfg_data
);

  // Stage map: sort, divider stages, three adjust stages, channel stages.
  localparam int DQ  = hsvc_pkg::SQ_W;
  localparam int ADJ = 1 + DQ;
  localparam int CHS = ADJ + 3;
  localparam int L   = CHS + hsvc_pkg::CH_STAGES;

  logic [L-1:0] vld_r, en;

  // A stage may load when any stage from it to the output has room.
  always_comb begin
    for (int i = 0; i < L; i++) begin
      en[i] = out_ready || ((vld_r >> i) != ({L{1'b1}} >> i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < L; i++) begin
        if (en[i]) vld_r[i] <= (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[L-1];

  // Configuration registers.
  logic signed [hsvc_pkg::ROT_W-1:0] hue_rot_r;
  logic signed [hsvc_pkg::OFS_W-1:0] sat_off_r, val_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_rot_r <= '0;
      sat_off_r <= '0;
      val_off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsvc_pkg::CFG_HUE_ROT: hue_rot_r <= cfg_data;
        hsvc_pkg::CFG_SAT_OFF: sat_off_r <= cfg_data[hsvc_pkg::OFS_W-1:0];
        hsvc_pkg::CFG_VAL_OFF: val_off_r <= cfg_data[hsvc_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Forward conversion setup.
  logic [hsvc_pkg::SNUM_W-1:0] snum, onum;
  logic [hsvc_pkg::SDEN_W-1:0] sden, oden;
  hsvc_pkg::side_t side;

  hsvc_fwd u_fwd (
    .clk   (clk),
    .en    (en[0]),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .snum  (snum),
    .sden  (sden),
    .onum  (onum),
    .oden  (oden),
    .side  (side)
  );

  // Saturation and hue offset dividers run side by side.
  logic [DQ-1:0] s_quo, off_quo;

  hsvc_div #(
    .NW (hsvc_pkg::SNUM_W),
    .DW (hsvc_pkg::SDEN_W),
    .QW (DQ)
  ) u_sdiv (
    .clk (clk),
    .en  (en[ADJ-1:1]),
    .num (snum),
    .den (sden),
    .quo (s_quo)
  );

  hsvc_div #(
    .NW (hsvc_pkg::SNUM_W),
    .DW (hsvc_pkg::SDEN_W),
    .QW (DQ)
  ) u_odiv (
    .clk (clk),
    .en  (en[ADJ-1:1]),
    .num (onum),
    .den (oden),
    .quo (off_quo)
  );

  logic [hsvc_pkg::V_W-1:0] s_adj, v_adj;
  logic [hsvc_pkg::K_W-1:0] k_red, k_green, k_blue;

  hsvc_adj u_adj (
    .clk     (clk),
    .en_dly  (en[ADJ-1:1]),
    .en      (en[CHS-1:ADJ]),
    .side_in (side),
    .s_quo   (s_quo),
    .off_quo (off_quo),
    .hue_rot (hue_rot_r),
    .sat_off (sat_off_r),
    .val_off (val_off_r),
    .s_out   (s_adj),
    .v_out   (v_adj),
    .k_red   (k_red),
    .k_green (k_green),
    .k_blue  (k_blue)
  );

  // One back conversion per channel; each gets its own shift.
  hsvc_chan u_chan_r (
    .clk (clk), .en (en[L-1:CHS]), .s (s_adj), .v (v_adj), .k (k_red),   .chan (out_red)
  );

  hsvc_chan u_chan_g (
    .clk (clk), .en (en[L-1:CHS]), .s (s_adj), .v (v_adj), .k (k_green), .chan (out_green)
  );

  hsvc_chan u_chan_b (
    .clk (clk), .en (en[L-1:CHS]), .s (s_adj), .v (v_adj), .k (k_blue),  .chan (out_blue)
  );

  // An empty or draining output stage means the whole pipe can take a word.
  `HSVC_ASSERT_NOW(a_ready_when_free, clk, rst_n, (!out_valid || out_ready), in_ready, "input stalled with free pipe")
  // An accepted word lands in the first stage.
  `HSVC_ASSERT_NEXT(a_accept_lands, clk, rst_n, (in_valid && in_ready), vld_r[0], "accepted word lost at entry")
  // A held stage keeps its word.
  `HSVC_ASSERT_NEXT(a_hold_mid, clk, rst_n, (vld_r[ADJ] && !en[ADJ]), vld_r[ADJ], "held word dropped in pipe")

endmodule

/* sv/hsvc_fwd.sv */
// Forward stage: sorts the channels, looks up value, sets up both dividers.
// Depends on hsvc_pkg.
module hsvc_fwd (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hsvc_pkg::CH_W-1:0]    red,
  input  logic [hsvc_pkg::CH_W-1:0]    green,
  input  logic [hsvc_pkg::CH_W-1:0]    blue,
  output logic [hsvc_pkg::SNUM_W-1:0]  snum,
  output logic [hsvc_pkg::SDEN_W-1:0]  sden,
  output logic [hsvc_pkg::SNUM_W-1:0]  onum,
  output logic [hsvc_pkg::SDEN_W-1:0]  oden,
  output hsvc_pkg::side_t              side
);

  logic [hsvc_pkg::CH_W-1:0] mx, mn, md, diff, dmid;
  hsvc_pkg::side_t side_nxt;
  logic [hsvc_pkg::SNUM_W-1:0] snum_nxt, onum_nxt;

  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
    md = hsvc_pkg::CH_W'((hsvc_pkg::CH_W + 2)'(red) + (hsvc_pkg::CH_W + 2)'(green)
         + (hsvc_pkg::CH_W + 2)'(blue) - (hsvc_pkg::CH_W + 2)'(mx)
         - (hsvc_pkg::CH_W + 2)'(mn));
    diff = mx - mn;
    dmid = md - mn;
    side_nxt.v = hsvc_pkg::V_LUT[mx];
    side_nxt.info.gray  = (mx == mn);
    side_nxt.info.black = (mx == '0);
    if (mx == red) begin
      side_nxt.info.sector = hsvc_pkg::SEC_RED;
      side_nxt.info.plus   = (md == green);
    end else if (mx == green) begin
      side_nxt.info.sector = hsvc_pkg::SEC_GREEN;
      side_nxt.info.plus   = (md == blue);
    end else begin
      side_nxt.info.sector = hsvc_pkg::SEC_BLUE;
      side_nxt.info.plus   = (md == red);
    end
    snum_nxt = hsvc_pkg::SNUM_W'(diff) * hsvc_pkg::SNUM_W'(2 * hsvc_pkg::FULL)
               + hsvc_pkg::SNUM_W'(mx);
    onum_nxt = hsvc_pkg::SNUM_W'(dmid) * hsvc_pkg::SNUM_W'(2 * hsvc_pkg::DEG60)
               + hsvc_pkg::SNUM_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snum <= snum_nxt;
      sden <= {mx, 1'b0};
      onum <= onum_nxt;
      oden <= {diff, 1'b0};
      side <= side_nxt;
    end
  end

endmodule

/* sv/hsvc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the quotient must fit in QW bits.
module hsvc_div #(
  parameter int NW = 20,
  parameter int DW = 9,
  parameter int QW = 11
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [RW:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in = RW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign trial = {1'b0, rem_in} - ((RW + 1)'(den_in) << (QW - 1 - j));

    always_ff @(posedge clk) begin
      if (en[j]) begin
        q_r[j] <= {q_in[QW-2:0], ~trial[RW]};
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j] <= trial[RW] ? rem_in : trial[RW-1:0];
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

/* sv/hsvc_adj.sv */
// Adjustment stages: hue assembly, rotation and wrap, saturation and value
// offsets, then sector decode into one shift per channel. Depends on hsvc_pkg.
module hsvc_adj (
  input  logic                              clk,
  input  logic [hsvc_pkg::SQ_W-1:0]         en_dly,
  input  logic [2:0]                        en,
  input  hsvc_pkg::side_t                   side_in,
  input  logic [hsvc_pkg::SQ_W-1:0]         s_quo,
  input  logic [hsvc_pkg::SQ_W-1:0]         off_quo,
  input  logic signed [hsvc_pkg::ROT_W-1:0] hue_rot,
  input  logic signed [hsvc_pkg::OFS_W-1:0] sat_off,
  input  logic signed [hsvc_pkg::OFS_W-1:0] val_off,
  output logic [hsvc_pkg::V_W-1:0]          s_out,
  output logic [hsvc_pkg::V_W-1:0]          v_out,
  output logic [hsvc_pkg::K_W-1:0]          k_red,
  output logic [hsvc_pkg::K_W-1:0]          k_green,
  output logic [hsvc_pkg::K_W-1:0]          k_blue
);

  localparam int HS_W = hsvc_pkg::H_W + 2;
  localparam int AS_W = hsvc_pkg::V_W + 2;
  localparam int DS_W = hsvc_pkg::H_W + 1;
  localparam logic [hsvc_pkg::K_W-1:0] KMAX = hsvc_pkg::K_W'(hsvc_pkg::DEG60);

  // Side data rides along with the divider stages.
  hsvc_pkg::side_t side_r [hsvc_pkg::SQ_W];
  for (genvar j = 0; j < hsvc_pkg::SQ_W; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en_dly[j]) begin
        if (j == 0) side_r[j] <= side_in;
        else side_r[j] <= side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  hsvc_pkg::side_t side;
  assign side = side_r[hsvc_pkg::SQ_W-1];

  logic [hsvc_pkg::H_W-1:0] base;
  logic [hsvc_pkg::V_W-1:0] s0;
  logic signed [HS_W-1:0] h1_nxt, h1_r;
  logic signed [AS_W-1:0] st, vt;
  logic [hsvc_pkg::V_W-1:0] s1_nxt, s1_r, v1_nxt, v1_r;
  logic [hsvc_pkg::H_W-1:0] off;

  always_comb begin
    off = hsvc_pkg::H_W'(off_quo);
    base = '0;
    if (!side.info.gray) begin
      unique case (side.info.sector)
        hsvc_pkg::SEC_RED: begin
          if (side.info.plus || off == '0) base = off;
          else base = hsvc_pkg::H_W'(hsvc_pkg::TURN) - off;
        end
        hsvc_pkg::SEC_GREEN: begin
          base = side.info.plus ? hsvc_pkg::H_W'(2 * hsvc_pkg::DEG60) + off
                                : hsvc_pkg::H_W'(2 * hsvc_pkg::DEG60) - off;
        end
        hsvc_pkg::SEC_BLUE: begin
          base = side.info.plus ? hsvc_pkg::H_W'(4 * hsvc_pkg::DEG60) + off
                                : hsvc_pkg::H_W'(4 * hsvc_pkg::DEG60) - off;
        end
        default: base = '0;
      endcase
    end
    h1_nxt = $signed({2'b00, base}) + HS_W'(hue_rot);

    s0 = side.info.black ? '0 : s_quo;
    st = $signed({2'b00, s0}) + AS_W'(sat_off);
    if (s0 == '0) s1_nxt = '0;
    else if (st < 0) s1_nxt = '0;
    else if (st > AS_W'(hsvc_pkg::FULL)) s1_nxt = hsvc_pkg::V_W'(hsvc_pkg::FULL);
    else s1_nxt = st[hsvc_pkg::V_W-1:0];

    vt = $signed({2'b00, side.v}) + AS_W'(val_off);
    if (vt < 0) v1_nxt = '0;
    else if (vt > AS_W'(hsvc_pkg::FULL)) v1_nxt = hsvc_pkg::V_W'(hsvc_pkg::FULL);
    else v1_nxt = vt[hsvc_pkg::V_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1_r <= h1_nxt;
      s1_r <= s1_nxt;
      v1_r <= v1_nxt;
    end
  end

  // Wrap into 0..TURN; TURN itself stays and counts as red.
  logic signed [HS_W-1:0] hw;
  logic [hsvc_pkg::H_W-1:0] h2_r;
  logic [hsvc_pkg::V_W-1:0] s2_r, v2_r;

  always_comb begin
    if (h1_r > HS_W'(2 * hsvc_pkg::TURN)) hw = h1_r - HS_W'(2 * hsvc_pkg::TURN);
    else if (h1_r > HS_W'(hsvc_pkg::TURN)) hw = h1_r - HS_W'(hsvc_pkg::TURN);
    else if (h1_r < -HS_W'(hsvc_pkg::TURN)) hw = h1_r + HS_W'(2 * hsvc_pkg::TURN);
    else if (h1_r < 0) hw = h1_r + HS_W'(hsvc_pkg::TURN);
    else hw = h1_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      h2_r <= hw[hsvc_pkg::H_W-1:0];
      s2_r <= s1_r;
      v2_r <= v1_r;
    end
  end

  logic signed [DS_W-1:0] d, dabs, hs;
  logic [hsvc_pkg::K_W-1:0] kr_nxt, kg_nxt, kb_nxt, kd;

  always_comb begin
    hs = $signed({1'b0, h2_r});
    if (h2_r >= hsvc_pkg::H_W'(hsvc_pkg::DEG60) && h2_r < hsvc_pkg::H_W'(3 * hsvc_pkg::DEG60))
      d = hs - DS_W'(2 * hsvc_pkg::DEG60);
    else if (h2_r >= hsvc_pkg::H_W'(3 * hsvc_pkg::DEG60)
             && h2_r < hsvc_pkg::H_W'(5 * hsvc_pkg::DEG60))
      d = hs - DS_W'(4 * hsvc_pkg::DEG60);
    else if (h2_r < hsvc_pkg::H_W'(2 * hsvc_pkg::DEG60))
      d = hs;
    else
      d = hs - DS_W'(hsvc_pkg::TURN);
    dabs = (d < 0) ? -d : d;
    kd = dabs[hsvc_pkg::K_W-1:0];
    if (h2_r >= hsvc_pkg::H_W'(hsvc_pkg::DEG60) && h2_r < hsvc_pkg::H_W'(3 * hsvc_pkg::DEG60))
    begin
      kg_nxt = KMAX;
      kr_nxt = (d < 0) ? kd : '0;
      kb_nxt = (d < 0) ? '0 : kd;
    end else if (h2_r >= hsvc_pkg::H_W'(3 * hsvc_pkg::DEG60)
                 && h2_r < hsvc_pkg::H_W'(5 * hsvc_pkg::DEG60)) begin
      kb_nxt = KMAX;
      kg_nxt = (d < 0) ? kd : '0;
      kr_nxt = (d < 0) ? '0 : kd;
    end else begin
      kr_nxt = KMAX;
      kb_nxt = (d < 0) ? kd : '0;
      kg_nxt = (d < 0) ? '0 : kd;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      k_red   <= kr_nxt;
      k_green <= kg_nxt;
      k_blue  <= kb_nxt;
      s_out   <= s2_r;
      v_out   <= v2_r;
    end
  end

endmodule

/* sv/hsvc_chan.sv */
// Back conversion of one channel: exact product, then rounded division by a
// reciprocal multiplication. Depends on hsvc_pkg.
module hsvc_chan (
  input  logic                                clk,
  input  logic [hsvc_pkg::CH_STAGES-1:0]      en,
  input  logic [hsvc_pkg::V_W-1:0]            s,
  input  logic [hsvc_pkg::V_W-1:0]            v,
  input  logic [hsvc_pkg::K_W-1:0]            k,
  output logic [hsvc_pkg::CH_W-1:0]           chan
);

  localparam int A_W = hsvc_pkg::V_W + hsvc_pkg::CH_W;
  localparam int B_W = 21;
  localparam int X_W = hsvc_pkg::CNUM_W - hsvc_pkg::CSHIFT;
  localparam int P_W = X_W + hsvc_pkg::CREC_W;

  logic [A_W-1:0] a_r;
  logic [B_W-1:0] b_r;
  logic [hsvc_pkg::CNUM_W-1:0] n_r;
  logic [P_W-1:0] p_r;
  logic [hsvc_pkg::CH_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r <= A_W'(v) * A_W'(hsvc_pkg::MAXC);
      b_r <= B_W'(hsvc_pkg::V_W'(hsvc_pkg::FULL) - s) * B_W'(hsvc_pkg::DEG60)
             + B_W'(s) * B_W'(k);
    end
    if (en[1]) begin
      n_r <= hsvc_pkg::CNUM_W'(a_r) * hsvc_pkg::CNUM_W'(b_r) + hsvc_pkg::CHALF;
    end
    if (en[2]) begin
      p_r <= P_W'(n_r[hsvc_pkg::CNUM_W-1:hsvc_pkg::CSHIFT]) * P_W'(hsvc_pkg::CREC);
    end
    if (en[3]) begin
      // The quotient never exceeds full intensity.
      q_r <= p_r[hsvc_pkg::CREC_SH +: hsvc_pkg::CH_W];
    end
  end

  assign chan = q_r;

endmodule

/* tb/sv/hsv_color_adjust_test.sv */
// Self-checking testbench for the HSV color adjust block (hsv_color_adjust).
// Depends on hsvc_pkg and the block's RTL; it predicts every pixel word on its own.
`timescale 1ns / 1ps

module hsv_color_adjust_test;

  localparam int RANDOM_WORDS = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = hsvc_pkg::CFG_HUE_ROT;
  logic [hsvc_pkg::CFG_W-1:0] cfg_data = '0;

  // Pixels waiting to be offered, and adjusted pixels waiting to come out.
  pixel_t pixel_queue[$];
  pixel_t adjusted_queue[$];

  // Register copies of the predictor.
  int hue_rot, sat_ofs, val_ofs;

  // Register settings of the random phases, in and beyond the usual range.
  int hue_set[6] = '{5760, -5760, 8191, -8192, 960, -17};
  int sat_set[6] = '{1600, -1600, 2047, -2048, 333, -1};
  int val_set[6] = '{-1600, 1600, -2048, 2047, -250, 1};

  int errors = 0;
  int cycles = 0;
  bit in_taken = 1'b0;
  bit steady = 1'b0;      // no random idling on either side while set
  int hold_cycles = 0;    // receiver hold-off, counts down at each falling edge

  hsv_color_adjust dut (.*);

  always #5 clk = ~clk;

  // One output channel, exactly rounded: MAXC*V*((FULL-S)*DEG60 + S*k) over
  // FULL^2*DEG60, ties up, clamped to full intensity.
  function automatic logic [7:0] channel_level(int v, int s, int k);
    longint unsigned num, q;
    num = longint'(hsvc_pkg::MAXC) * v
          * (longint'(hsvc_pkg::FULL - s) * hsvc_pkg::DEG60 + longint'(s) * k);
    q = (num + longint'(hsvc_pkg::CHALF)) / longint'(hsvc_pkg::CDEN);
    if (q > hsvc_pkg::MAXC) q = hsvc_pkg::MAXC;
    return q[7:0];
  endfunction

  function automatic int round_div(int num, int den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t p);
    int r, g, b, mx, mn, md, h, s, v, off, shift;
    logic [7:0] cmin, cr, cg, cb;
    bit plus;
    r = p.red; g = p.green; b = p.blue;
    mx = r > g ? r : g;
    if (b > mx) mx = b;
    mn = r < g ? r : g;
    if (b < mn) mn = b;
    md = r + g + b - mx - mn;
    h = 0;
    v = round_div(hsvc_pkg::FULL * mx, hsvc_pkg::MAXC);
    s = (mx == 0) ? 0 : round_div(hsvc_pkg::FULL * (mx - mn), mx);
    // Gray pixels keep hue zero; ties for the maximum prefer red, then green.
    if (mx != mn) begin
      off = round_div(hsvc_pkg::DEG60 * (md - mn), mx - mn);
      if (mx == r) begin
        plus = (md == g);
        h = plus ? off : -off;
        if (h < 0) h += hsvc_pkg::TURN;
      end else if (mx == g) begin
        plus = (md == b);
        h = 2 * hsvc_pkg::DEG60 + (plus ? off : -off);
      end else begin
        plus = (md == r);
        h = 4 * hsvc_pkg::DEG60 + (plus ? off : -off);
      end
    end
    h += hue_rot;
    while (h > hsvc_pkg::TURN) h -= hsvc_pkg::TURN;
    while (h < 0) h += hsvc_pkg::TURN;
    // A black or gray pixel has no saturation and takes no saturation offset.
    if (s > 0) begin
      s += sat_ofs;
      if (s > hsvc_pkg::FULL) s = hsvc_pkg::FULL;
      if (s < 0) s = 0;
    end
    v += val_ofs;
    if (v > hsvc_pkg::FULL) v = hsvc_pkg::FULL;
    if (v < 0) v = 0;
    cmin = channel_level(v, s, 0);
    if (h >= hsvc_pkg::DEG60 && h < 3 * hsvc_pkg::DEG60) begin
      shift = h - 2 * hsvc_pkg::DEG60;
      cg = channel_level(v, s, hsvc_pkg::DEG60);
      if (shift < 0) begin cb = cmin; cr = channel_level(v, s, -shift); end
      else begin cr = cmin; cb = channel_level(v, s, shift); end
    end else if (h >= 3 * hsvc_pkg::DEG60 && h < 5 * hsvc_pkg::DEG60) begin
      shift = h - 4 * hsvc_pkg::DEG60;
      cb = channel_level(v, s, hsvc_pkg::DEG60);
      if (shift < 0) begin cr = cmin; cg = channel_level(v, s, -shift); end
      else begin cg = cmin; cr = channel_level(v, s, shift); end
    end else begin
      // A hue of exactly a full turn lands here and counts as red.
      shift = (h < 2 * hsvc_pkg::DEG60) ? h : h - hsvc_pkg::TURN;
      cr = channel_level(v, s, hsvc_pkg::DEG60);
      if (shift < 0) begin cg = cmin; cb = channel_level(v, s, -shift); end
      else begin cb = cmin; cg = channel_level(v, s, shift); end
    end
    return '{red: cr, green: cg, blue: cb};
  endfunction

  // Input side: offer the next pixel at the falling edge once the previous
  // word has gone in; idle now and then unless a steady stretch is on.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pixel_queue.size() > 0 && (steady || $urandom_range(99) >= 12)) begin
        pixel_t p;
        p = pixel_queue.pop_front();
        in_red <= p.red;
        in_green <= p.green;
        in_blue <= p.blue;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: a long hold-off lets the pipeline fill and stall its input.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && (steady || $urandom_range(99) >= 12);
    end
  end

  // Monitor: predict each accepted pixel, check each returned word.
  always @(posedge clk) begin
    pixel_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      adjusted_queue.push_back(adjust_pixel('{red: in_red, green: in_green, blue: in_blue}));
    if (rst_n && out_valid && out_ready) begin
      got = '{red: out_red, green: out_green, blue: out_blue};
      if (adjusted_queue.size() == 0) begin
        $error("pixel word with nothing expected: %h", got);
        errors++;
      end else begin
        want = adjusted_queue.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red); errors++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green); errors++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid || adjusted_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= hsvc_pkg::CFG_W'(value);
    case (idx)
      hsvc_pkg::CFG_HUE_ROT: hue_rot = $signed(hsvc_pkg::ROT_W'(value));
      hsvc_pkg::CFG_SAT_OFF: sat_ofs = $signed(hsvc_pkg::OFS_W'(value));
      default:               val_ofs = $signed(hsvc_pkg::OFS_W'(value));
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pixel(int r, int g, int b);
    pixel_queue.push_back('{red: 8'(r), green: 8'(g), blue: 8'(b)});
  endtask

  // Mostly colorful pixels, with grays, primaries and plain noise mixed in.
  task automatic add_random_pixels(int count);
    int k, sel;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        add_pixel($urandom_range(255), 0, 0);
      end else if (sel == 1) begin
        sel = $urandom_range(255);
        add_pixel(sel, sel, sel);
      end else if (sel == 2) begin
        add_pixel($urandom_range(1) * 255, $urandom_range(1) * 255, $urandom_range(1) * 255);
      end else begin
        add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  initial begin
    int ph;
    hue_rot = 0; sat_ofs = 0; val_ofs = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels at reset settings: black, white, grays, primaries,
    // secondaries, ties for the maximum and each hue sector direction.
    add_pixel(0, 0, 0);       add_pixel(255, 255, 255); add_pixel(128, 128, 128);
    add_pixel(255, 0, 0);     add_pixel(0, 255, 0);     add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);   add_pixel(0, 255, 255);   add_pixel(255, 0, 255);
    add_pixel(255, 0, 1);     add_pixel(255, 1, 0);     add_pixel(1, 255, 0);
    add_pixel(0, 255, 1);     add_pixel(1, 0, 255);     add_pixel(0, 1, 255);
    add_pixel(1, 0, 0);       add_pixel(200, 200, 10);  add_pixel(10, 200, 200);
    add_pixel(200, 10, 200);  add_pixel(254, 1, 127);   add_pixel(85, 170, 255);
    wait_drained();
    write_reg(hsvc_pkg::CFG_HUE_ROT, 5760);
    write_reg(hsvc_pkg::CFG_SAT_OFF, 1600);
    write_reg(hsvc_pkg::CFG_VAL_OFF, -1600);
    add_pixel(255, 0, 0); add_pixel(0, 0, 0); add_pixel(90, 90, 90); add_pixel(30, 200, 60);
    wait_drained();

    // Random phases; the first runs without idling and with a long stall.
    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_reg(hsvc_pkg::CFG_HUE_ROT, hue_set[ph - 1]);
        write_reg(hsvc_pkg::CFG_SAT_OFF, sat_set[ph - 1]);
        write_reg(hsvc_pkg::CFG_VAL_OFF, val_set[ph - 1]);
      end else begin
        write_reg(hsvc_pkg::CFG_HUE_ROT, 0);
        write_reg(hsvc_pkg::CFG_SAT_OFF, 0);
        write_reg(hsvc_pkg::CFG_VAL_OFF, 0);
      end
      steady = (ph == 0);
      add_random_pixels(RANDOM_WORDS / 7);
      if (ph == 0) begin
        repeat (40) @(posedge clk);
        @(negedge clk);
        hold_cycles = 200;
      end
      wait_drained();
    end

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
